@@ design/smpq_pkg.sv @@
// shared types and codes for the sorted max priority queue
package smpq_pkg;

	localparam int VAL_W = 32;
	localparam int OCC_W = 5;

	// command codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_ENQ   = 2'd0,
		ST_DEQ   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic               enq;
		logic               deq;
		logic signed [VAL_W-1:0] value;
	} cell_ctrl_t;

	// one result as it sits in the output buffer
	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] removed_value;
		logic [OCC_W-1:0]        occupancy;
	} result_t;

endpackage

@@ design/smpq_cell.sv @@
// one slot of the sorted chain: holds an entry and shifts with its neighbors
module smpq_cell
	import smpq_pkg::*;
(
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic                    occupied,
	input  logic signed [VAL_W-1:0] left_value,
	input  logic                    left_ge,
	input  logic signed [VAL_W-1:0] right_value,
	output logic signed [VAL_W-1:0] entry_q,
	output logic                    ge
);

	// entry stays ahead of the new value when it is at least as large
	assign ge = occupied && (entry_q >= ctrl.value);

	// keep, take the new value, shift right on enqueue, shift left on dequeue
	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!ge) begin
				entry_q <= left_ge ? ctrl.value : left_value;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_value;
		end
	end

endmodule

@@ design/smpq_out_buf.sv @@
// two-deep output buffer: head register plus skid register
module smpq_out_buf
	import smpq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t head_q
);

	logic    head_valid_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    pop;

	assign pop       = head_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = head_valid_q;

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					head_valid_q <= push;
				end
			end else if (!head_valid_q) begin
				head_valid_q <= push;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (!head_valid_q) begin
			if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	// skid only fills behind a waiting head
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> head_valid_q)
		else $error("skid register valid without head");

	// a stalled head with a skid entry keeps both
	assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_stall) |=> (skid_valid_q && $stable(head_q)))
		else $error("buffered request lost under stall");

endmodule

@@ design/sorted_max_priority_queue.sv @@
// top level of the sorted max priority queue built as a chain of cells
//
//  channel | direction | handshake           | payload
//  in      | into      | in_valid/in_stall   | command, value
//  out     | out of    | out_valid/out_stall | status, removed_value, occupancy
//
// one request is accepted per cycle while in_stall is low; its result is registered in the output buffer.
// every cell compares and shifts in the same cycle, so the rate is set by
// one 32-bit compare plus the neighbor select in each cell.
// reset clears the entry count and the output buffer; entries need no clear.
// in_stall rises only while two results wait in the output buffer.
module sorted_max_priority_queue
	import smpq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    command,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] removed_value,
	output logic [OCC_W-1:0]        occupancy
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]        count_q;
	logic                    push;
	logic                    is_full;
	logic                    is_empty;
	cell_ctrl_t              ctrl;
	logic signed [VAL_W-1:0] cell_value [CAPACITY];
	logic                    cell_ge [CAPACITY];
	logic [CNT_W-1:0]        next_count;
	logic [CNT_W+OCC_W-1:0]  occ_ext;
	result_t                 res;
	result_t                 head;
	logic                    buf_full;

	assign push     = in_valid && !in_stall;
	assign in_stall = buf_full;
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// cell controls
	assign ctrl.enq   = push && (command == CMD_ENQ) && !is_full;
	assign ctrl.deq   = push && (command == CMD_DEQ) && !is_empty;
	assign ctrl.value = value;

	// chain of cells, largest at index zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] lv;
		logic                    lg;
		logic signed [VAL_W-1:0] rv;
		if (i == 0) begin : g_first
			assign lv = value;
			assign lg = 1'b1;
		end else begin : g_mid
			assign lv = cell_value[i-1];
			assign lg = cell_ge[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rv = cell_value[i];
		end else begin : g_inner
			assign rv = cell_value[i+1];
		end
		smpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (count_q > CNT_W'(i)),
			.left_value  (lv),
			.left_ge     (lg),
			.right_value (rv),
			.entry_q     (cell_value[i]),
			.ge          (cell_ge[i])
		);
	end

	// entry count
	always_comb begin
		next_count = count_q;
		if (ctrl.enq) begin
			next_count = count_q + CNT_W'(1);
		end else if (ctrl.deq) begin
			next_count = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= next_count;
		end
	end

	// result for this request
	assign occ_ext = {{OCC_W{1'b0}}, next_count};

	always_comb begin
		res.occupancy     = occ_ext[OCC_W-1:0];
		res.removed_value = '0;
		if (command == CMD_ENQ) begin
			res.status = is_full ? ST_FULL : ST_ENQ;
		end else if (is_empty) begin
			res.status = ST_EMPTY;
		end else begin
			res.status        = ST_DEQ;
			res.removed_value = cell_value[0];
		end
	end

	smpq_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head_q    (head)
	);

	assign status        = head.status;
	assign removed_value = head.removed_value;
	assign occupancy     = head.occupancy;

	// count never passes the capacity
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// an enqueue with room grows the count by one
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.enq |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("enqueue did not grow count");

	// a rejected request leaves the count alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !ctrl.enq && !ctrl.deq) |=> $stable(count_q))
		else $error("rejected request changed count");

endmodule
